/* hdl/lrp_pkg.sv */
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants of the lidar range-to-point core.
// ----------------------------------------------------------------------------
package lrp_pkg;

    localparam int CfgAddrW = 2;
    localparam logic [CfgAddrW-1:0] CFG_HFOV   = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_VFOV   = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_COLS   = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_LAYERS = 2'd3;

    localparam int CordicSteps = 24;
    localparam int CordicW     = 30;
    localparam logic signed [CordicW-1:0] Q24_PI      = 30'sd52707179;
    localparam logic signed [CordicW-1:0] Q24_HALF_PI = 30'sd26353589;
    localparam logic signed [CordicW-1:0] Q24_GAIN    = 30'sd10188014;

    // sine/cosine pair in signed Q1.16
    typedef struct packed {
        logic signed [17:0] sin;
        logic signed [17:0] cos;
    } trig_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_L_GO, ST_L_DIV, ST_L_COR, ST_H_GO, ST_H_DIV, ST_H_COR,
        ST_RD0, ST_MT, ST_MZ, ST_RD1, ST_MX, ST_MY, ST_OUT, ST_ADV
    } state_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] k);
        logic [23:0] v;
        case (k)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            default: v = (k < 5'd24) ? (24'd1 << (5'd24 - k)) : 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/lrp_divider.sv */
// ----------------------------------------------------------------------------
// lrp_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrp_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [13:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [14:0] rem_reg, rem_next;
    logic [13:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [15:0] trial;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[31]} - {2'b0, dvs_reg};
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit and subtract if it fits
            if (!trial[15]) begin
                rem_next = trial[14:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[13:0], q_reg[31]};
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start) dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

/* hdl/lrp_cordic.sv */
// ----------------------------------------------------------------------------
// lrp_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q1.16 out.
// ----------------------------------------------------------------------------
module lrp_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [19:0]  angle,
    output logic                done,
    output lrp_pkg::trig_t      result
);
    localparam int W = lrp_pkg::CordicW;

    logic signed [W-1:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic signed [W-1:0] z0, xf, yf, sx, sy, at;
    logic                flip_reg, flip_next, busy_reg, busy_next, done_reg, done_next;
    logic [4:0]          k_reg, k_next;
    lrp_pkg::trig_t      res_reg, res_next;

    function automatic logic signed [17:0] round_clamp(input logic signed [W-1:0] v);
        logic [W-1:0] m;
        logic [W-1:0] r;
        m = v[W-1] ? W'(-v) : W'(v);
        r = (m + W'(128)) >> 8;
        if (r > W'(65536)) r = W'(65536);
        return v[W-1] ? -18'(r) : 18'(r);
    endfunction

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        z0        = W'(angle) <<< 8;
        sx        = x_reg >>> k_reg;
        sy        = y_reg >>> k_reg;
        at        = W'(lrp_pkg::atan_q24(k_reg));
        xf        = flip_reg ? -x_reg : x_reg;
        yf        = flip_reg ? -y_reg : y_reg;
        if (start) begin
            // fold into +-pi/2 and negate at the end
            flip_next = 1'b0;
            z_next    = z0;
            if (z0 > lrp_pkg::Q24_HALF_PI) begin
                z_next    = z0 - lrp_pkg::Q24_PI;
                flip_next = 1'b1;
            end else if (z0 < -lrp_pkg::Q24_HALF_PI) begin
                z_next    = z0 + lrp_pkg::Q24_PI;
                flip_next = 1'b1;
            end
            x_next    = lrp_pkg::Q24_GAIN;
            y_next    = '0;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (k_reg == 5'(lrp_pkg::CordicSteps)) begin
                res_next.cos = round_clamp(xf);
                res_next.sin = round_clamp(yf);
                busy_next    = 1'b0;
                done_next    = 1'b1;
            end else begin
                if (!z_reg[W-1]) begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + at;
                end
                k_next = k_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        k_reg    <= k_next;
        flip_reg <= flip_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

/* hdl/lrp_trig_ram.sv */
// ----------------------------------------------------------------------------
// lrp_trig_ram
// Two-entry store of sine/cosine pairs: layer angle and column angle.
// ----------------------------------------------------------------------------
module lrp_trig_ram (
    input  logic           aclk,
    input  logic           we,
    input  logic           waddr,
    input  lrp_pkg::trig_t wdata,
    input  logic           raddr,
    output lrp_pkg::trig_t rdata
);
    lrp_pkg::trig_t mem [2];
    lrp_pkg::trig_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/lidar_range_to_point_core.sv */
// ----------------------------------------------------------------------------
// lidar_range_to_point_core
// Converts float32 lidar ranges into Cartesian Q16.16 points.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample with a valid range, from its
// transaction on the slave side until the input is ready again, is dominated by
// two passes of a bit-serial divider (centred layer and column angles) and two
// CORDIC passes. The rest is a start state per divider pass, read-back from the
// sine/cosine store and four products on one shared multiplier, an output state
// and the idle state that accepts the sample. Samples with an invalid range (NaN,
// infinity, zero, negative) skip the column pass and yield no transaction on the
// master side. The next sample is taken as soon as the previous point is in the
// output register, even if it is not yet taken downstream. If a point is still
// waiting there, the new point is held until it is taken, which adds those stall
// cycles. Configuration writes must only happen while idle.
module lidar_range_to_point_core #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_LAYERS  = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [lrp_pkg::CfgAddrW-1:0]   cfg_index,
    input  logic [18:0]                    cfg_wdata,
    // sample input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // range_bits
    input  logic                           s_tuser,   // start_of_frame
    // point output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], column_number[107:96],
    // layer_number[114:108], zero pad [119:115]
    output logic [119:0]                   m_tdata
);
    lrp_pkg::state_t state_reg, state_next;

    logic [18:0] hfov_reg;
    logic [17:0] vfov_reg;
    logic [12:0] cols_cfg_reg;
    logic [7:0]  lays_cfg_reg;
    logic [11:0] col_reg;
    logic [6:0]  lay_reg;
    logic [31:0] r_reg;
    logic        rvalid_reg;
    logic        dneg_reg;
    logic signed [34:0] t_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [119:0] mdata_reg;
    logic        mvalid_reg;

    logic [12:0] cols;
    logic [7:0]  lays;

    // clamp the counts to at least one and to the supported maxima
    always_comb begin
        cols = cols_cfg_reg;
        if (cols == 13'd0) cols = 13'd1;
        if (32'(cols) > MAX_COLUMNS) cols = 13'(MAX_COLUMNS);
        if (cols > 13'd4096) cols = 13'd4096;
        lays = lays_cfg_reg;
        if (lays == 8'd0) lays = 8'd1;
        if (32'(lays) > MAX_LAYERS) lays = 8'(MAX_LAYERS);
        if (lays > 8'd128) lays = 8'd128;
    end

    // float32 -> unsigned Q16.16, truncating; saturate at 65536 m
    logic [7:0]  fexp;
    logic [23:0] fsig;
    logic signed [9:0] fsh;
    logic [31:0] conv_q16;
    logic        conv_ok;
    always_comb begin
        fexp    = s_tdata[30:23];
        fsig    = (fexp == 8'd0) ? {1'b0, s_tdata[22:0]} : {1'b1, s_tdata[22:0]};
        fsh     = 10'(signed'({2'b0, (fexp == 8'd0) ? 8'd1 : fexp})) - 10'sd134;
        conv_ok = !(fexp == 8'hFF) && !(s_tdata[30:0] == 31'd0) && !s_tdata[31];
        if (fsh > 10'sd8)        conv_q16 = 32'hFFFF_FFFF;
        else if (fsh >= 10'sd0)  conv_q16 = {8'd0, fsig} << fsh[3:0];
        else if (fsh > -10'sd32) conv_q16 = {8'd0, fsig} >> 5'(-fsh);
        else                     conv_q16 = '0;
    end

    // counters adjusted for start of frame and lowered counts
    logic [12:0] col_a;
    logic [7:0]  lay_a;
    always_comb begin
        col_a = s_tuser ? 13'd0 : {1'b0, col_reg};
        lay_a = s_tuser ? 8'd0  : {1'b0, lay_reg};
        if (col_a >= cols) begin
            col_a = '0;
            lay_a = lay_a + 8'd1;
        end
        if (lay_a >= lays) lay_a = '0;
    end

    // advance after the sample
    logic [12:0] col_inc;
    logic [7:0]  lay_inc;
    always_comb begin
        col_inc = {1'b0, col_reg} + 13'd1;
        lay_inc = {1'b0, lay_reg};
        if (col_inc >= cols) begin
            col_inc = '0;
            lay_inc = lay_inc + 8'd1;
            if (lay_inc >= lays) lay_inc = '0;
        end
    end

    // centred angle numerator: fov*|2i+1-n| + n over 2n
    logic        horiz;
    logic signed [14:0] dval;
    logic [12:0] dmag;
    logic [18:0] fov_sel;
    logic [12:0] n_sel;
    logic [31:0] dividend;
    always_comb begin
        horiz    = (state_reg == lrp_pkg::ST_H_GO);
        n_sel    = horiz ? cols : {5'd0, lays};
        fov_sel  = horiz ? hfov_reg : {1'b0, vfov_reg};
        dval     = horiz ? signed'({2'b0, col_reg, 1'b1}) - signed'({2'b0, n_sel})
                         : signed'({7'b0, lay_reg, 1'b1}) - signed'({2'b0, n_sel});
        dmag     = dval[14] ? 13'(-dval) : 13'(dval);
        dividend = 32'(fov_sel) * 32'(dmag) + 32'(n_sel);
    end

    logic        div_start, div_done;
    logic [31:0] quot;
    lrp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  ({n_sel, 1'b0}),
        .done     (div_done),
        .quotient (quot)
    );

    logic              cor_start, cor_done;
    logic signed [19:0] angle;
    lrp_pkg::trig_t    cor_res;
    assign angle = dneg_reg ? -signed'(quot[19:0]) : signed'(quot[19:0]);
    lrp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (angle),
        .done    (cor_done),
        .result  (cor_res)
    );

    logic           ram_we, ram_waddr, ram_raddr;
    lrp_pkg::trig_t ram_rdata;
    lrp_trig_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cor_res),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sign-magnitude Q16 product with rounding half away from zero
    function automatic logic signed [37:0] mul_q16(input logic signed [34:0] a,
                                                   input logic signed [17:0] b);
        logic [33:0] am;
        logic [16:0] bm;
        logic [50:0] p;
        logic [36:0] r;
        am = a[34] ? 34'(-a) : 34'(a);
        bm = b[17] ? 17'(-b) : 17'(b);
        p  = 51'(am) * 51'(bm);
        r  = 37'((p + 51'd32768) >> 16);
        return (a[34] ^ b[17]) ? -signed'({1'b0, r}) : signed'({1'b0, r});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -38'sd2147483648) return 32'sh8000_0000;
        else                           return 32'(v);
    endfunction

    logic signed [17:0] mul_b;
    logic signed [34:0] mul_a;
    logic signed [37:0] prod;
    always_comb begin
        mul_a = (state_reg == lrp_pkg::ST_MX || state_reg == lrp_pkg::ST_MY)
                ? t_reg : signed'({3'b0, r_reg});
        mul_b = (state_reg == lrp_pkg::ST_MZ || state_reg == lrp_pkg::ST_MX)
                ? ram_rdata.sin : ram_rdata.cos;
        prod  = mul_q16(mul_a, mul_b);
    end

    logic out_free;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        cor_start  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = 1'b0;
        ram_raddr  = 1'b0;
        s_tready   = (state_reg == lrp_pkg::ST_IDLE);
        unique case (state_reg)
            lrp_pkg::ST_IDLE:  if (s_tvalid) state_next = lrp_pkg::ST_L_GO;
            lrp_pkg::ST_L_GO: begin
                div_start  = 1'b1;
                state_next = lrp_pkg::ST_L_DIV;
            end
            lrp_pkg::ST_L_DIV: if (div_done) begin
                cor_start  = 1'b1;
                state_next = lrp_pkg::ST_L_COR;
            end
            lrp_pkg::ST_L_COR: if (cor_done) begin
                ram_we     = 1'b1;
                state_next = rvalid_reg ? lrp_pkg::ST_H_GO : lrp_pkg::ST_ADV;
            end
            lrp_pkg::ST_H_GO: begin
                div_start  = 1'b1;
                state_next = lrp_pkg::ST_H_DIV;
            end
            lrp_pkg::ST_H_DIV: if (div_done) begin
                cor_start  = 1'b1;
                state_next = lrp_pkg::ST_H_COR;
            end
            lrp_pkg::ST_H_COR: if (cor_done) begin
                ram_we     = 1'b1;
                ram_waddr  = 1'b1;
                state_next = lrp_pkg::ST_RD0;
            end
            lrp_pkg::ST_RD0:   state_next = lrp_pkg::ST_MT;
            lrp_pkg::ST_MT:    state_next = lrp_pkg::ST_MZ;
            lrp_pkg::ST_MZ: begin
                ram_raddr  = 1'b1;
                state_next = lrp_pkg::ST_RD1;
            end
            lrp_pkg::ST_RD1: begin
                ram_raddr  = 1'b1;
                state_next = lrp_pkg::ST_MX;
            end
            lrp_pkg::ST_MX: begin
                ram_raddr  = 1'b1;
                state_next = lrp_pkg::ST_MY;
            end
            lrp_pkg::ST_MY: begin
                ram_raddr  = 1'b1;
                state_next = lrp_pkg::ST_OUT;
            end
            lrp_pkg::ST_OUT:   if (out_free) state_next = lrp_pkg::ST_IDLE;
            lrp_pkg::ST_ADV:   state_next = lrp_pkg::ST_IDLE;
            default:           state_next = lrp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lrp_pkg::ST_IDLE;
            hfov_reg     <= 19'd196608;
            vfov_reg     <= 18'd67502;
            cols_cfg_reg <= 13'd512;
            lays_cfg_reg <= 8'd16;
            col_reg      <= '0;
            lay_reg      <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    lrp_pkg::CFG_HFOV:   hfov_reg     <= cfg_wdata;
                    lrp_pkg::CFG_VFOV:   vfov_reg     <= cfg_wdata[17:0];
                    lrp_pkg::CFG_COLS:   cols_cfg_reg <= cfg_wdata[12:0];
                    lrp_pkg::CFG_LAYERS: lays_cfg_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // hold the sample's position through the whole transaction
            if (s_tvalid && s_tready) begin
                col_reg <= col_a[11:0];
                lay_reg <= lay_a[6:0];
            end
            if (state_reg == lrp_pkg::ST_OUT && out_free) begin
                mvalid_reg <= 1'b1;
                col_reg    <= col_inc[11:0];
                lay_reg    <= lay_inc[6:0];
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            if (state_reg == lrp_pkg::ST_ADV) begin
                col_reg <= col_inc[11:0];
                lay_reg <= lay_inc[6:0];
            end
        end
        if (s_tvalid && s_tready) begin
            r_reg      <= conv_q16;
            rvalid_reg <= conv_ok;
        end
        if (div_start) dneg_reg <= dval[14];
        if (state_reg == lrp_pkg::ST_MT) t_reg  <= 35'(prod);
        if (state_reg == lrp_pkg::ST_MZ) pz_reg <= sat32(prod);
        if (state_reg == lrp_pkg::ST_MX) px_reg <= sat32(prod);
        if (state_reg == lrp_pkg::ST_MY) py_reg <= sat32(prod);
        if (state_reg == lrp_pkg::ST_OUT && out_free)
            mdata_reg <= {5'd0, lay_reg, col_reg, pz_reg, py_reg, px_reg};
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
endmodule
